/* rtl/lfw_pkg.sv */
package lfw_pkg;

  // Generator geometry.
  localparam int LONG_LAG  = 10;
  localparam int SHORT_LAG = 7;
  localparam int GAP       = LONG_LAG - SHORT_LAG;
  localparam int IDX_W     = $clog2(LONG_LAG);

  // Field widths.
  localparam int FRAC_W     = 53;
  localparam int SEED_W     = 32;
  localparam int BITS_W     = 32;
  localparam int SEED_SHIFT = FRAC_W - SEED_W;
  localparam int SVAL_W     = FRAC_W + 1;

  // Working store: three banks (lag buffer, inner Weyl, outer Weyl) of 2**IDX_W words.
  localparam int ADDR_W    = IDX_W + 2;
  localparam int MEM_DEPTH = 3 * (1 << IDX_W);

  // Weyl increment and modulus.
  localparam logic [FRAC_W-1:0] WEYL_C = 53'd5566755282872655;
  localparam logic [FRAC_W-1:0] WEYL_R = 53'd9007199254740881;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LONG_LAG - 1);

  // Bank codes.
  localparam logic [1:0] BANK_U = 2'd0;
  localparam logic [1:0] BANK_Z = 2'd1;
  localparam logic [1:0] BANK_W = 2'd2;

  // Slot offset codes, relative to the loop index.
  localparam logic [1:0] OFF_I     = 2'd0;
  localparam logic [1:0] OFF_IM1   = 2'd1;
  localparam logic [1:0] OFF_IMGAP = 2'd2;
  localparam logic [1:0] OFF_IPS   = 2'd3;

  // Operand A source.
  localparam logic A_MEM  = 1'b0;
  localparam logic A_SEED = 1'b1;

  // Operand B source.
  localparam logic [1:0] B_MEM  = 2'd0;
  localparam logic [1:0] B_C    = 2'd1;
  localparam logic [1:0] B_R    = 2'd2;
  localparam logic [1:0] B_ZERO = 2'd3;

  // Subtraction modulus.
  localparam logic MOD_53 = 1'b0;
  localparam logic MOD_R  = 1'b1;

  // Jump conditions on the loop index.
  localparam logic [1:0] CND_NONE    = 2'd0;
  localparam logic [1:0] CND_NE_LAST = 2'd1;
  localparam logic [1:0] CND_NE_GAP  = 2'd2;
  localparam logic [1:0] CND_NE_ZERO = 2'd3;

  // Loop index updates.
  localparam logic [1:0] I_HOLD = 2'd0;
  localparam logic [1:0] I_INC  = 2'd1;
  localparam logic [1:0] I_DEC  = 2'd2;
  localparam logic [1:0] I_SET1 = 2'd3;

  // Program counter and entry points.
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_RESEED = PC_W'(0);
  localparam logic [PC_W-1:0] PC_REFILL = PC_W'(6);

  // One microcode control word.
  typedef struct packed {
    logic            mod_r;
    logic            a_src;
    logic [1:0]      b_src;
    logic [1:0]      a_bank;
    logic [1:0]      a_off;
    logic [1:0]      b_bank;
    logic [1:0]      b_off;
    logic [1:0]      d_bank;
    logic [1:0]      d_off;
    logic [1:0]      cond;
    logic [PC_W-1:0] target;
    logic [1:0]      i_taken;
    logic [1:0]      i_fall;
    logic            last;
    logic            load_pos;
  } ucode_t;

  // Datapath controls from the sequencer.
  typedef struct packed {
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              a_src;
    logic [1:0]        b_src;
    logic              mod_r;
  } ctrl_t;

  function automatic ucode_t mk(
    input logic            mod_r,
    input logic            a_src,
    input logic [1:0]      b_src,
    input logic [1:0]      a_bank,
    input logic [1:0]      a_off,
    input logic [1:0]      b_bank,
    input logic [1:0]      b_off,
    input logic [1:0]      d_bank,
    input logic [1:0]      d_off,
    input logic [1:0]      cond,
    input logic [PC_W-1:0] target,
    input logic [1:0]      i_taken,
    input logic [1:0]      i_fall,
    input logic            last,
    input logic            load_pos
  );
    ucode_t cw;
    cw.mod_r    = mod_r;
    cw.a_src    = a_src;
    cw.b_src    = b_src;
    cw.a_bank   = a_bank;
    cw.a_off    = a_off;
    cw.b_bank   = b_bank;
    cw.b_off    = b_off;
    cw.d_bank   = d_bank;
    cw.d_off    = d_off;
    cw.cond     = cond;
    cw.target   = target;
    cw.i_taken  = i_taken;
    cw.i_fall   = i_fall;
    cw.last     = last;
    cw.load_pos = load_pos;
    return cw;
  endfunction

  // Microprogram. Reseed runs with the index starting at 0, refill with it at the last slot.
  function automatic ucode_t ucode_fetch(input logic [PC_W-1:0] pc);
    ucode_t cw;
    case (pc)
      // Reseed: z[0] = s mod R, w[0] = s mod R, U[0] = s mod 2^53.
      4'd0: cw = mk(MOD_R, A_SEED, B_R, BANK_U, OFF_I, BANK_U, OFF_I, BANK_Z, OFF_I,
                    CND_NONE, PC_W'(0), I_HOLD, I_HOLD, 1'b0, 1'b0);
      4'd1: cw = mk(MOD_R, A_SEED, B_R, BANK_U, OFF_I, BANK_U, OFF_I, BANK_W, OFF_I,
                    CND_NONE, PC_W'(0), I_HOLD, I_HOLD, 1'b0, 1'b0);
      4'd2: cw = mk(MOD_53, A_SEED, B_ZERO, BANK_U, OFF_I, BANK_U, OFF_I, BANK_U, OFF_I,
                    CND_NONE, PC_W'(0), I_HOLD, I_SET1, 1'b0, 1'b0);
      // Reseed loop: z[i] = z[i-1] - C, w[i] = w[i-1] - z[i], U[i] = w[i].
      4'd3: cw = mk(MOD_R, A_MEM, B_C, BANK_Z, OFF_IM1, BANK_Z, OFF_I, BANK_Z, OFF_I,
                    CND_NONE, PC_W'(0), I_HOLD, I_HOLD, 1'b0, 1'b0);
      4'd4: cw = mk(MOD_R, A_MEM, B_MEM, BANK_W, OFF_IM1, BANK_Z, OFF_I, BANK_W, OFF_I,
                    CND_NONE, PC_W'(0), I_HOLD, I_HOLD, 1'b0, 1'b0);
      4'd5: cw = mk(MOD_53, A_MEM, B_ZERO, BANK_W, OFF_I, BANK_W, OFF_I, BANK_U, OFF_I,
                    CND_NE_LAST, PC_W'(3), I_INC, I_HOLD, 1'b1, 1'b1);
      // Refill, upper slots: U[i] -= U[i-GAP], index descending.
      4'd6: cw = mk(MOD_53, A_MEM, B_MEM, BANK_U, OFF_I, BANK_U, OFF_IMGAP, BANK_U, OFF_I,
                    CND_NE_GAP, PC_W'(6), I_DEC, I_DEC, 1'b0, 1'b0);
      // Refill, lower slots: U[i] -= U[i+SHORT_LAG], index descending to 0.
      4'd7: cw = mk(MOD_53, A_MEM, B_MEM, BANK_U, OFF_I, BANK_U, OFF_IPS, BANK_U, OFF_I,
                    CND_NE_ZERO, PC_W'(7), I_DEC, I_HOLD, 1'b0, 1'b0);
      // Refill, Weyl pass: z -= C, w -= z, U -= w on every slot.
      4'd8: cw = mk(MOD_R, A_MEM, B_C, BANK_Z, OFF_I, BANK_Z, OFF_I, BANK_Z, OFF_I,
                    CND_NONE, PC_W'(0), I_HOLD, I_HOLD, 1'b0, 1'b0);
      4'd9: cw = mk(MOD_R, A_MEM, B_MEM, BANK_W, OFF_I, BANK_Z, OFF_I, BANK_W, OFF_I,
                    CND_NONE, PC_W'(0), I_HOLD, I_HOLD, 1'b0, 1'b0);
      4'd10: cw = mk(MOD_53, A_MEM, B_MEM, BANK_U, OFF_I, BANK_W, OFF_I, BANK_U, OFF_I,
                     CND_NE_LAST, PC_W'(8), I_INC, I_HOLD, 1'b1, 1'b0);
      // Unused codes: rewrite U[i] unchanged and end.
      default: cw = mk(MOD_53, A_MEM, B_ZERO, BANK_U, OFF_I, BANK_U, OFF_I, BANK_U, OFF_I,
                       CND_NONE, PC_W'(0), I_HOLD, I_HOLD, 1'b1, 1'b0);
    endcase
    return cw;
  endfunction

  // Slot number for an offset code at loop index i.
  function automatic logic [IDX_W-1:0] slot_of(input logic [1:0] off,
                                               input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] s;
    case (off)
      OFF_I:     s = i;
      OFF_IM1:   s = i - IDX_W'(1);
      OFF_IMGAP: s = i - IDX_W'(GAP);
      OFF_IPS:   s = i + IDX_W'(SHORT_LAG);
      default:   s = i;
    endcase
    return s;
  endfunction

  // Loop index update.
  function automatic logic [IDX_W-1:0] i_step(input logic [1:0] op,
                                              input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] n;
    case (op)
      I_HOLD:  n = i;
      I_INC:   n = i + IDX_W'(1);
      I_DEC:   n = i - IDX_W'(1);
      I_SET1:  n = IDX_W'(1);
      default: n = i;
    endcase
    return n;
  endfunction

endpackage

/* rtl/lfw_ifs.sv */
// Request channel: one transaction asks for the next number.
interface lfw_req_if import lfw_pkg::*; ();
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

// Result channel: one transaction carries one number.
interface lfw_rsp_if import lfw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FRAC_W-1:0] fraction;
  logic [BITS_W-1:0] bits32;
  modport source (output valid, output fraction, output bits32, input ready);
  modport sink (input valid, input fraction, input bits32, output ready);
endinterface

// Configuration channel: one transaction writes the seed register.
interface lfw_cfg_if import lfw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SEED_W-1:0] seed;
  modport source (output valid, output seed, input ready);
  modport sink (input valid, input seed, output ready);
endinterface

/* rtl/lfw_datapath.sv */
module lfw_datapath import lfw_pkg::*; (
  input  logic              clk,
  input  logic [SEED_W-1:0] seed,
  input  ctrl_t             ctrl,
  output logic [FRAC_W-1:0] rd_frac
);

  logic [FRAC_W-1:0] mem_r [MEM_DEPTH];
  logic [FRAC_W-1:0] rd_a_r;
  logic [FRAC_W-1:0] rd_b_r;
  logic [SVAL_W-1:0] seed_val_r;
  logic [SVAL_W-1:0] seed_val_nxt;
  logic [SVAL_W-1:0] a_op;
  logic [FRAC_W-1:0] b_op;
  logic [SVAL_W:0]   diff;
  logic [FRAC_W-1:0] wrapped;
  logic [FRAC_W-1:0] wr_data;

  // Seed scaled to 0.53 fixed point: seed*2^21 plus seed/2^11 rounded to nearest.
  assign seed_val_nxt = {1'b0, seed, SEED_SHIFT'(0)}
                      + SVAL_W'(seed[SEED_W-1:SEED_W-SEED_SHIFT])
                      + SVAL_W'(seed[SEED_W-SEED_SHIFT-1]);

  always_ff @(posedge clk) begin
    seed_val_r <= seed_val_nxt;
  end

  // Working store with two registered read ports and one write port.
  always_ff @(posedge clk) begin
    rd_a_r <= mem_r[ctrl.rd_addr_a];
    rd_b_r <= mem_r[ctrl.rd_addr_b];
    if (ctrl.wr_en) begin
      mem_r[ctrl.wr_addr] <= wr_data;
    end
  end

  // Operand selection.
  always_comb begin
    a_op = (ctrl.a_src == A_SEED) ? seed_val_r : {1'b0, rd_a_r};
    case (ctrl.b_src)
      B_MEM:   b_op = rd_b_r;
      B_C:     b_op = WEYL_C;
      B_R:     b_op = WEYL_R;
      default: b_op = '0;
    endcase
  end

  // Shared subtractor: modulo 2^53, or modulo R by adding R back on a borrow.
  assign diff    = {1'b0, a_op} - {2'b00, b_op};
  assign wrapped = diff[FRAC_W-1:0] + WEYL_R;
  assign wr_data = (ctrl.mod_r == MOD_R && diff[SVAL_W]) ? wrapped : diff[FRAC_W-1:0];

  assign rd_frac = rd_a_r;

endmodule

/* rtl/lagged_fib_weyl_generator.sv */
// A taken request passes through the READ and PUT states, and the result register loads
// once it is free. A restart first runs the reseed program (30 microsteps on the shared
// subtractor). No new request is taken until the number is handed over; the refill program
// (40 microsteps) runs after each number from the last slot: the first after a reseed, then
// every tenth. Reset: synchronous, active low; afterwards the reseed program runs with
// seed 0 before the first request is taken. Seed writes wait while a program runs.
module lagged_fib_weyl_generator import lfw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  lfw_req_if.sink   in_if,
  lfw_rsp_if.source out_if,
  lfw_cfg_if.sink   cfg_if
);

  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_PUT  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic              phase_r, phase_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic              pend_r, pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [FRAC_W-1:0] out_frac_r, out_frac_nxt;
  logic [SEED_W-1:0] seed_r, seed_nxt;

  ucode_t            cw;
  ctrl_t             ctrl;
  logic              taken;
  logic              in_acc;
  logic [FRAC_W-1:0] rd_frac;

  lfw_datapath u_datapath (
    .clk     (clk),
    .seed    (seed_r),
    .ctrl    (ctrl),
    .rd_frac (rd_frac)
  );

  // The seed register stays stable while the reseed program reads it.
  assign in_if.ready     = (state_r == ST_IDLE);
  assign in_acc          = in_if.valid && in_if.ready;
  assign cfg_if.ready    = (state_r != ST_BUSY);
  assign out_if.valid    = out_valid_r;
  assign out_if.fraction = out_frac_r;
  assign out_if.bits32   = out_frac_r[FRAC_W-1 -: BITS_W];

  // Microcode fetch and jump condition.
  always_comb begin
    cw = ucode_fetch(pc_r);
    case (cw.cond)
      CND_NONE:    taken = 1'b0;
      CND_NE_LAST: taken = (i_r != LAST_IDX);
      CND_NE_GAP:  taken = (i_r != IDX_W'(GAP));
      CND_NE_ZERO: taken = (i_r != '0);
      default:     taken = 1'b0;
    endcase
  end

  // Datapath control: microcode addresses while busy, otherwise the current read slot.
  always_comb begin
    ctrl.a_src   = cw.a_src;
    ctrl.b_src   = cw.b_src;
    ctrl.mod_r   = cw.mod_r;
    ctrl.wr_addr = {cw.d_bank, slot_of(cw.d_off, i_r)};
    ctrl.wr_en   = (state_r == ST_BUSY) && phase_r;
    if (state_r == ST_BUSY) begin
      ctrl.rd_addr_a = {cw.a_bank, slot_of(cw.a_off, i_r)};
      ctrl.rd_addr_b = {cw.b_bank, slot_of(cw.b_off, i_r)};
    end else begin
      ctrl.rd_addr_a = {BANK_U, pos_r};
      ctrl.rd_addr_b = {BANK_U, pos_r};
    end
  end

  // Sequencer and output register.
  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    phase_nxt     = phase_r;
    i_nxt         = i_r;
    pos_nxt       = pos_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    out_frac_nxt  = out_frac_r;
    seed_nxt      = seed_r;

    if (cfg_if.valid && cfg_if.ready) begin
      seed_nxt = cfg_if.seed;
    end

    if (out_if.valid && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_BUSY: begin
        // Each microstep reads while phase_r is low and writes back while it is high.
        if (!phase_r) begin
          phase_nxt = 1'b1;
        end else begin
          phase_nxt = 1'b0;
          if (taken) begin
            pc_nxt = cw.target;
            i_nxt  = i_step(cw.i_taken, i_r);
          end else if (cw.last) begin
            i_nxt = i_step(cw.i_fall, i_r);
            if (cw.load_pos) begin
              pos_nxt = LAST_IDX;
            end
            state_nxt = pend_r ? ST_READ : ST_IDLE;
          end else begin
            pc_nxt = pc_r + PC_W'(1);
            i_nxt  = i_step(cw.i_fall, i_r);
          end
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          pend_nxt = 1'b1;
          if (in_if.restart) begin
            state_nxt = ST_BUSY;
            pc_nxt    = PC_RESEED;
            phase_nxt = 1'b0;
            i_nxt     = '0;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_PUT;
      end
      ST_PUT: begin
        // Hand the word over once the output register is free; refill after the last slot.
        if (!out_valid_r || out_if.ready) begin
          out_frac_nxt  = rd_frac;
          out_valid_nxt = 1'b1;
          pend_nxt      = 1'b0;
          if (pos_r == LAST_IDX) begin
            pos_nxt   = '0;
            state_nxt = ST_BUSY;
            pc_nxt    = PC_REFILL;
            phase_nxt = 1'b0;
            i_nxt     = LAST_IDX;
          end else begin
            pos_nxt   = pos_r + IDX_W'(1);
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers; reset starts the reseed program.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_BUSY;
      pc_r        <= PC_RESEED;
      phase_r     <= 1'b0;
      i_r         <= '0;
      pos_r       <= LAST_IDX;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      seed_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      phase_r     <= phase_nxt;
      i_r         <= i_nxt;
      pos_r       <= pos_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      seed_r      <= seed_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    out_frac_r <= out_frac_nxt;
  end

endmodule
